// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the palette pixel unpacker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// A condition that must hold at every clock edge out of reset.
`define CHECK_ALWAYS(lbl, clock, reset, cond, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define CHECK_SAME(lbl, clock, reset, trig, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define CHECK_NEXT(lbl, clock, reset, trig, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) else $error(msg);

`else

`define CHECK_ALWAYS(lbl, clock, reset, cond, msg)
`define CHECK_SAME(lbl, clock, reset, trig, cons, msg)
`define CHECK_NEXT(lbl, clock, reset, trig, cons, msg)

`endif

`endif

// ===== hdl/bpu_pkg.sv =====
// Package of the palette pixel unpacker: sizes, codes and the queued job record.
`default_nettype none

package bpu_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Register and field widths.
  localparam int DIM_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 20;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT) + 1;
  localparam int STRIDE_W = DIM_W + 1;
  localparam int X_W      = $clog2(MAX_WIDTH) + 3;
  localparam int CNT_W    = 4;
  localparam int K_W      = 3;

  // Job queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Pixel depth codes.
  localparam logic [1:0] DEPTH_1BPP = 2'd0;
  localparam logic [1:0] DEPTH_4BPP = 2'd1;
  localparam logic [1:0] DEPTH_8BPP = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 2'd2;

  // One byte that yields pixels, as the back needs it.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [1:0]        depth;
    logic [CNT_W-1:0]  count;
    logic [X_W-1:0]    x_start;
    logic [ADDR_W-1:0] row_base;
    logic              frame_end;
  } job_t;

endpackage

`default_nettype wire

// ===== hdl/bmp_palette_pixel_unpack.sv =====
// Top level of the palettized BMP pixel-data unpacker.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in      | in        | in_valid / in_stall   | data_byte
//  out     | out       | out_valid / out_stall | pixel_index, pixel_address, last_of_byte,
//          |           |                       | frame_done
//
// One pixel leaves per cycle while out_stall is low, and a byte yields up to eight pixels at
// 1 bpp, two at 4 bpp and one at 8 bpp; that pace is set by the single pixel output register of the back.
// A byte is classified in the cycle it is accepted and written into the job queue; its pixels
// reach the output register from the queue head. Padding bytes are accepted but yield no
// pixels. Reset is synchronous and returns width 1, height 1 and 8 bpp.
// A stalled output holds its pixel; the four-entry job queue then fills and raises in_stall.
`default_nettype none

`include "assert_macros.svh"

module bmp_palette_pixel_unpack import bpu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    pixel_index,
  output logic [ADDR_W-1:0]    pixel_address,
  output logic                 last_of_byte,
  output logic                 frame_done
);

  // The front keeps the progress counters and turns every byte that yields pixels into a
  // job: the byte, its depth, the pixel count, the first column and the row base address.
  // The row base is the one multiplication, (height - 1 - row) * width, done at accept.
  logic job_push;
  job_t job;
  logic q_full;
  logic q_empty;
  logic q_pop;
  job_t q_head;

  bpu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .q_full    (q_full),
    .job_push  (job_push),
    .job       (job)
  );

  // The queue lets the front go on taking requests while the back is still unpacking an
  // earlier byte or is held by a stalled output.
  bpu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // The back works straight off the queue head and pops it with the last pixel, so bytes
  // follow one another without a gap cycle.
  bpu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .head          (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_index   (pixel_index),
    .pixel_address (pixel_address),
    .last_of_byte  (last_of_byte),
    .frame_done    (frame_done)
  );

  // The final pixel of the image is always the last one taken from its byte.
  `CHECK_SAME(a_done_is_last, clk, rst, out_valid && frame_done, last_of_byte, "frame_done without last_of_byte")

  // Nothing can follow the final pixel of the image.
  `CHECK_NEXT(a_quiet_after_done, clk, rst, out_valid && !out_stall && frame_done, !out_valid, "pixel after frame end")

  // Pixels of one byte leave back to back at consecutive addresses.
  `CHECK_NEXT(a_byte_contiguous, clk, rst, out_valid && !out_stall && !last_of_byte, out_valid && (pixel_address == $past(pixel_address) + ADDR_W'(1)), "byte pixels not contiguous")

endmodule

`default_nettype wire

// ===== hdl/bpu_front.sv =====
// Front of the unpacker: configuration registers, row and column tracking, job building.
`default_nettype none

module bpu_front import bpu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic                 q_full,
  output logic                 job_push,
  output job_t                 job
);

  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [1:0]         depth_code;
  logic [COL_W-1:0]   byte_column;
  logic [ROW_W-1:0]   file_row;
  logic               image_complete;

  logic [DIM_W-1:0]    w_eff;
  logic [DIM_W-1:0]    h_eff;
  logic [1:0]          depth_sel;
  logic [CNT_W-1:0]    per_byte;
  logic [STRIDE_W-1:0] round_sum;
  logic [STRIDE_W-1:0] stride;
  logic [X_W-1:0]      x0;
  logic [X_W-1:0]      w_x;
  logic [X_W-1:0]      remain;
  logic                in_row;
  logic [CNT_W-1:0]    n_pix;
  logic                row_ok;
  logic                frame_hit;
  logic [ROW_W-1:0]    rows_left;
  logic [2*DIM_W-1:0]  prod_full;
  logic [STRIDE_W-1:0] col_next;
  logic [ROW_W-1:0]    row_next;
  logic                accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  // Out-of-range sizes are clamped into 1..MAX.
  always_comb begin
    if (image_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (image_width > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (image_height > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  // Row stride is the bit count rounded up to whole 32-bit words, in bytes.
  always_comb begin
    unique case (depth_code)
      DEPTH_1BPP: begin
        depth_sel = DEPTH_1BPP;
        per_byte  = CNT_W'(8);
        round_sum = {1'b0, w_eff} + STRIDE_W'(31);
        stride    = STRIDE_W'({round_sum[STRIDE_W-1:5], 2'b00});
        x0        = X_W'({byte_column, 3'b000});
      end
      DEPTH_4BPP: begin
        depth_sel = DEPTH_4BPP;
        per_byte  = CNT_W'(2);
        round_sum = {1'b0, w_eff} + STRIDE_W'(7);
        stride    = STRIDE_W'({round_sum[STRIDE_W-1:3], 2'b00});
        x0        = X_W'({byte_column, 1'b0});
      end
      default: begin
        depth_sel = DEPTH_8BPP;
        per_byte  = CNT_W'(1);
        round_sum = {1'b0, w_eff} + STRIDE_W'(3);
        stride    = STRIDE_W'({round_sum[STRIDE_W-1:2], 2'b00});
        x0        = X_W'(byte_column);
      end
    endcase
  end

  assign w_x    = X_W'(w_eff);
  assign in_row = x0 < w_x;
  assign remain = w_x - x0;

  always_comb begin
    if (!in_row) begin
      n_pix = '0;
    end else if (remain > X_W'(per_byte)) begin
      n_pix = per_byte;
    end else begin
      n_pix = CNT_W'(remain);
    end
  end

  assign row_ok    = file_row < ROW_W'(h_eff);
  assign frame_hit = (file_row == ROW_W'(h_eff) - ROW_W'(1)) && in_row
                     && (remain <= X_W'(per_byte));
  assign rows_left = ROW_W'(h_eff) - ROW_W'(1) - file_row;
  assign prod_full = DIM_W'(rows_left) * w_eff;
  assign col_next  = STRIDE_W'(byte_column) + STRIDE_W'(1);
  assign row_next  = file_row + ROW_W'(1);

  assign job_push = accept && !image_complete && row_ok && (n_pix != '0);

  always_comb begin
    job.data_byte = data_byte;
    job.depth     = depth_sel;
    job.count     = n_pix;
    job.x_start   = x0;
    job.row_base  = prod_full[ADDR_W-1:0];
    job.frame_end = frame_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= DIM_W'(1);
      image_height   <= DIM_W'(1);
      depth_code     <= DEPTH_8BPP;
      byte_column    <= '0;
      file_row       <= '0;
      image_complete <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WIDTH:  image_width  <= cfg_data;
          REG_HEIGHT: image_height <= cfg_data;
          REG_DEPTH:  depth_code   <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (accept && !image_complete) begin
        if (!row_ok) begin
          image_complete <= 1'b1;
        end else begin
          if (frame_hit) begin
            image_complete <= 1'b1;
          end
          if (col_next >= stride) begin
            byte_column <= '0;
            file_row    <= row_next;
            if (row_next >= ROW_W'(h_eff)) begin
              image_complete <= 1'b1;
            end
          end else begin
            byte_column <= col_next[COL_W-1:0];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bpu_queue.sv =====
// Short job queue that decouples the byte front from the pixel back.
`default_nettype none

module bpu_queue import bpu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = count == QCNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bpu_back.sv =====
// Back of the unpacker: splits the job at the queue head into pixels, one per cycle while the output is not stalled.
`default_nettype none

module bpu_back import bpu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  job_t              head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] pixel_index,
  output logic [ADDR_W-1:0] pixel_address,
  output logic              last_of_byte,
  output logic              frame_done
);

  logic [K_W-1:0]    k;
  logic              advance;
  logic              emit;
  logic              is_last;
  logic [BYTE_W-1:0] idx;
  logic [ADDR_W-1:0] addr;

  assign advance = !out_valid || !out_stall;
  assign emit    = advance && !q_empty;
  assign is_last = (CNT_W'(k) + CNT_W'(1)) == head.count;
  assign q_pop   = emit && is_last;

  // Pixels are taken from the most significant end of the byte.
  always_comb begin
    case (head.depth)
      DEPTH_1BPP: idx = BYTE_W'(head.data_byte[K_W'(7) - k]);
      DEPTH_4BPP: idx = k[0] ? BYTE_W'(head.data_byte[3:0]) : BYTE_W'(head.data_byte[7:4]);
      default:    idx = head.data_byte;
    endcase
  end

  assign addr = head.row_base + ADDR_W'(head.x_start) + ADDR_W'(k);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (advance) begin
        out_valid <= !q_empty;
      end
      if (emit) begin
        k <= is_last ? '0 : k + K_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_index   <= idx;
      pixel_address <= addr;
      last_of_byte  <= is_last;
      frame_done    <= is_last && head.frame_end;
    end
  end

endmodule

`default_nettype wire
